@@ sv/fted_pkg.sv @@
// Shared types, constants and the entry classifier for the allocation table decoder.
// Depends on nothing; every other file of the block imports it.
package fted_pkg;

	// field widths
	localparam int IdxW  = 28;
	localparam int ValW  = 32;
	localparam int CfgW  = 28;
	localparam int OutW  = 64;

	// group queue between front and back
	localparam int QueueDepth = 4;
	localparam int QPtrW      = $clog2(QueueDepth);
	localparam int QCntW      = $clog2(QueueDepth + 1);

	// register indexes on the write port
	localparam logic REG_TABLE_FORMAT = 1'b0;
	localparam logic REG_ENTRY_COUNT  = 1'b1;

	// table format codes
	localparam logic [1:0] FMT_FAT12 = 2'd0;
	localparam logic [1:0] FMT_FAT16 = 2'd1;
	localparam logic [1:0] FMT_FAT32 = 2'd2;

	// entry classes
	localparam logic [1:0] CLS_FREE  = 2'd0;
	localparam logic [1:0] CLS_USED  = 2'd1;
	localparam logic [1:0] CLS_EOC   = 2'd2;
	localparam logic [1:0] CLS_OTHER = 2'd3;

	// saturation point of the entry index
	localparam logic [IdxW-1:0] IDX_MAX = 28'hFFF_FFFF;

	// one completed byte group, as handed from front to back
	typedef struct packed {
		logic [1:0]      fmt;
		logic [ValW-1:0] value;
		logic [IdxW-1:0] idx0;
		logic [IdxW-1:0] idx1;
		logic            emit0;
		logic            emit1;
	} group_t;

	// class of one entry value; FAT32 ignores the top four bits
	function automatic logic [1:0] classify(input logic [1:0] fmt, input logic [ValW-1:0] raw);
		logic [ValW-1:0] v;
		logic [ValW-1:0] end_lo;
		logic [ValW-1:0] end_hi;
		logic [ValW-1:0] used_hi;
		logic [1:0]      cls;
		v = raw;
		unique case (fmt)
			FMT_FAT12: begin
				end_lo = 32'h0000_0FF8; end_hi = 32'h0000_0FFF; used_hi = 32'h0000_0FEF;
			end
			FMT_FAT16: begin
				end_lo = 32'h0000_FFF8; end_hi = 32'h0000_FFFF; used_hi = 32'h0000_FFEF;
			end
			default: begin
				v = raw & 32'h0FFF_FFFF;
				end_lo = 32'h0FFF_FFF8; end_hi = 32'h0FFF_FFFF; used_hi = 32'h0FFF_FFEF;
			end
		endcase
		if (v == '0)
			cls = CLS_FREE;
		else if (v >= end_lo && v <= end_hi)
			cls = CLS_EOC;
		else if (v >= 32'd2 && v <= used_hi)
			cls = CLS_USED;
		else
			cls = CLS_OTHER;
		return cls;
	endfunction

endpackage

@@ sv/fat_table_entry_decoder.sv @@
// Allocation table decoder: a group's accepted closing byte passes the group queue,
// then the back part's output register, before its first entry word goes out on the
// master side. Throughput: one byte per cycle in unless the queue is full; one entry
// word per cycle out unless m_tready is low, set by the output register; a FAT12 group
// gives two words; the four-deep queue absorbs the burst. Reset (arst_n low) clears
// configuration, assembly, index, queue and output valid at once; no clearing pass.
module fat_table_entry_decoder (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_we,
	input  logic                     cfg_index,
	input  logic [fted_pkg::CfgW-1:0] cfg_data,
	input  logic                     s_tvalid,
	output logic                     s_tready,
	input  logic [7:0]               s_tdata,   // [7:0] table_byte
	input  logic                     s_tuser,   // [0] restart
	output logic                     m_tvalid,
	input  logic                     m_tready,
	output logic [fted_pkg::OutW-1:0] m_tdata,  // [27:0] entry_index, [59:28] entry_value,
	                                            // [61:60] entry_class, [63:62] zero
	output logic                     m_tlast    // run_last
);
	import fted_pkg::*;

	logic   q_push;
	logic   q_full;
	logic   q_pop;
	logic   q_valid;
	group_t q_in;
	group_t q_head;

	// front: configuration, assembly, index
	fted_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.table_byte (s_tdata),
		.restart    (s_tuser),
		.q_full     (q_full),
		.q_push     (q_push),
		.q_data     (q_in)
	);

	// group queue
	fted_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (q_push),
		.push_data  (q_in),
		.full       (q_full),
		.pop        (q_pop),
		.head_valid (q_valid),
		.head       (q_head)
	);

	// back: entry split, class, output register
	fted_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (q_valid),
		.head       (q_head),
		.pop        (q_pop),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.m_tlast    (m_tlast)
	);

endmodule

@@ sv/fted_front.sv @@
// Front part: configuration registers, byte assembly and index bookkeeping.
// Pushes into the queue one record per completed group with an entry below the entry count. Depends on fted_pkg.
module fted_front (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_we,
	input  logic                     cfg_index,
	input  logic [fted_pkg::CfgW-1:0] cfg_data,
	input  logic                     s_tvalid,
	output logic                     s_tready,
	input  logic [7:0]               table_byte,
	input  logic                     restart,
	input  logic                     q_full,
	output logic                     q_push,
	output fted_pkg::group_t         q_data
);
	import fted_pkg::*;

	logic [1:0]      fmt_raw_q;
	logic [IdxW-1:0] count_q;
	logic [1:0]      phase_q;
	logic [23:0]     asm_q;
	logic [IdxW-1:0] idx_q;

	logic [1:0]      fmt;
	logic [1:0]      last_pos;
	logic [1:0]      phase;
	logic [23:0]     asm_cur;
	logic [23:0]     asm_nxt;
	logic [IdxW-1:0] idx0;
	logic [IdxW-1:0] idx1;
	logic [IdxW-1:0] idx2;
	logic            accept;
	logic            complete;
	logic [ValW-1:0] value;

	// format code 3 behaves as FAT32
	always_comb begin
		unique case (fmt_raw_q)
			FMT_FAT12: begin fmt = FMT_FAT12; last_pos = 2'd2; end
			FMT_FAT16: begin fmt = FMT_FAT16; last_pos = 2'd1; end
			default:   begin fmt = FMT_FAT32; last_pos = 2'd3; end
		endcase
	end

	assign s_tready = !q_full;
	assign accept   = s_tvalid && s_tready;

	// restart clears assembly and index before the byte is taken
	assign phase   = restart ? 2'd0 : phase_q;
	assign asm_cur = restart ? 24'd0 : asm_q;
	assign idx0    = restart ? '0 : idx_q;
	assign complete = (phase >= last_pos);

	// saturating index steps
	assign idx1 = (idx0 == IDX_MAX) ? IDX_MAX : idx0 + 28'd1;
	assign idx2 = (idx0 >= IDX_MAX - 28'd1) ? IDX_MAX : idx0 + 28'd2;

	// group value from held bytes and the closing byte
	always_comb begin
		unique case (fmt)
			FMT_FAT12: value = {8'h00, table_byte, asm_cur[15:0]};
			FMT_FAT16: value = {16'h0000, table_byte, asm_cur[7:0]};
			default:   value = {table_byte, asm_cur};
		endcase
	end

	// byte placed into the assembly word
	always_comb begin
		asm_nxt = asm_cur;
		unique case (phase)
			2'd0:    asm_nxt[7:0]   = asm_cur[7:0]   | table_byte;
			2'd1:    asm_nxt[15:8]  = asm_cur[15:8]  | table_byte;
			2'd2:    asm_nxt[23:16] = asm_cur[23:16] | table_byte;
			default: asm_nxt = asm_cur;
		endcase
	end

	// record for the back part
	always_comb begin
		q_data.fmt   = fmt;
		q_data.value = value;
		q_data.idx0  = idx0;
		q_data.idx1  = idx1;
		q_data.emit0 = (idx0 < count_q);
		q_data.emit1 = (fmt == FMT_FAT12) && (idx1 < count_q);
	end
	assign q_push = accept && complete && (q_data.emit0 || q_data.emit1);

	// configuration, assembly and index state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fmt_raw_q <= FMT_FAT12;
			count_q   <= '0;
			phase_q   <= 2'd0;
			asm_q     <= 24'd0;
			idx_q     <= '0;
		end else begin
			if (cfg_we && cfg_index == REG_TABLE_FORMAT)
				fmt_raw_q <= cfg_data[1:0];
			if (cfg_we && cfg_index == REG_ENTRY_COUNT)
				count_q <= cfg_data[IdxW-1:0];
			if (accept) begin
				if (complete) begin
					phase_q <= 2'd0;
					asm_q   <= 24'd0;
					idx_q   <= (fmt == FMT_FAT12) ? idx2 : idx1;
				end else begin
					phase_q <= phase + 2'd1;
					asm_q   <= asm_nxt;
					idx_q   <= idx0;
				end
			end
		end
	end

endmodule

@@ sv/fted_queue.sv @@
// Short queue of completed group records between front and back.
// Depends on fted_pkg for the record type and depth.
module fted_queue (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  fted_pkg::group_t push_data,
	output logic             full,
	input  logic             pop,
	output logic             head_valid,
	output fted_pkg::group_t head
);
	import fted_pkg::*;

	group_t           mem_q [QueueDepth];
	logic [QPtrW-1:0] wr_ptr_q;
	logic [QPtrW-1:0] rd_ptr_q;
	logic [QCntW-1:0] cnt_q;

	assign full       = (cnt_q == QCntW'(QueueDepth));
	assign head_valid = (cnt_q != '0);
	assign head       = mem_q[rd_ptr_q];

	// record storage
	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= push_data;
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push)
				wr_ptr_q <= wr_ptr_q + QPtrW'(1);
			if (pop)
				rd_ptr_q <= rd_ptr_q + QPtrW'(1);
			if (push && !pop)
				cnt_q <= cnt_q + QCntW'(1);
			else if (pop && !push)
				cnt_q <= cnt_q - QCntW'(1);
		end
	end

endmodule

@@ sv/fted_back.sv @@
// Back part: splits group records into entry words, classes them and holds
// the output register. Depends on fted_pkg.
module fted_back (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     head_valid,
	input  fted_pkg::group_t         head,
	output logic                     pop,
	output logic                     m_tvalid,
	input  logic                     m_tready,
	output logic [fted_pkg::OutW-1:0] m_tdata,
	output logic                     m_tlast
);
	import fted_pkg::*;

	logic            valid_q;
	logic [OutW-1:0] data_q;
	logic            last_q;
	logic            half_q;

	logic            load;
	logic            first_pending;
	logic [IdxW-1:0] e_idx;
	logic [ValW-1:0] e_val;
	logic            e_last;

	assign load = head_valid && (!valid_q || m_tready);

	// pick the entry of the head record still to be sent
	assign first_pending = head.emit0 && !half_q;
	assign e_idx  = first_pending ? head.idx0 : head.idx1;
	assign e_last = first_pending ? !head.emit1 : 1'b1;

	always_comb begin
		if (head.fmt == FMT_FAT12)
			e_val = first_pending ? {20'h0, head.value[11:0]} : {20'h0, head.value[23:12]};
		else
			e_val = head.value;
	end

	assign pop = load && e_last;

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			half_q  <= 1'b0;
		end else begin
			if (!valid_q || m_tready)
				valid_q <= head_valid;
			if (load)
				half_q <= !e_last;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			data_q <= {2'b00, classify(head.fmt, e_val), e_val, e_idx};
			last_q <= e_last;
		end
	end

	assign m_tvalid = valid_q;
	assign m_tdata  = data_q;
	assign m_tlast  = last_q;

endmodule

@@ sv/fted_checker.sv @@
// Port-level checks on the decoder's master side, and the bind that attaches them.
// Depends on fted_pkg and on fat_table_entry_decoder.
module fted_checker (
	input logic                      clk,
	input logic                      arst_n,
	input logic                      m_tvalid,
	input logic                      m_tready,
	input logic [fted_pkg::OutW-1:0] m_tdata,
	input logic                      m_tlast
);
	import fted_pkg::*;

	// a stalled word holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
		else $error("output word changed while stalled");

	// padding bits stay zero
	a_pad: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[63:62] == 2'b00)
		else $error("padding bits set");

	// free class exactly when the significant value bits are zero
	a_free: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> ((m_tdata[55:28] == 28'd0) == (m_tdata[61:60] == CLS_FREE)))
		else $error("free class does not match value");

	// value one is a reserved mark in every format
	a_one: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[55:28] == 28'd1 |-> m_tdata[61:60] == CLS_OTHER)
		else $error("value one not classed as other");

endmodule

bind fat_table_entry_decoder fted_checker u_fted_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tlast  (m_tlast)
);
